### rtl/assert_macros.svh
// Assertion macros shared by the keyed count pool RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge while reset is released.
`define KCP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define KCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KCP_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define KCP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/kcp_pkg.sv
// Package for the keyed count pool: sizes, codes and the controller/datapath
// command and status types. No dependencies.
package kcp_pkg;

    localparam int ENTRIES  = 16;
    localparam int QTY_BITS = 16;

    localparam int KEY_W    = 32;
    localparam int AMT_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TAKE = 1'b1
    } t_kcp_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_CLOSED    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_kcp_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_WRITE,
        S_RESP
    } t_kcp_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic write;
    } t_kcp_cmd;

    typedef struct packed {
        logic scan_last;
    } t_kcp_sts;

endpackage

### rtl/kcp_ifs.sv
// Request and result channel interfaces of the keyed count pool.
// Depends on kcp_pkg for the field widths.
interface kcp_req_if import kcp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;

    modport source (output valid, output opcode, output key, output amount, input ready);
    modport sink   (input valid, input opcode, input key, input amount, output ready);
endinterface

interface kcp_rsp_if import kcp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [AMT_W-1:0]    taken;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
    logic                is_empty;

    modport source (output valid, output taken, output status, output occupancy,
                    output is_empty, input ready);
    modport sink   (input valid, input taken, input status, input occupancy,
                    input is_empty, output ready);
endinterface

### rtl/kcp_datapath.sv
// Datapath of the keyed count pool: entry memory, valid bits, scan compare,
// merge/take arithmetic and result registers. Depends on kcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kcp_datapath import kcp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  t_kcp_cmd            i_cmd,
    output t_kcp_sts            o_sts,
    input  logic                i_opcode,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [AMT_W-1:0]    i_amount,
    output logic [AMT_W-1:0]    o_taken,
    output logic [STATUS_W-1:0] o_status,
    output logic [OCC_W-1:0]    o_occupancy,
    output logic                o_is_empty
);

    localparam int WIDE_W = (QTY_BITS > AMT_W) ? QTY_BITS : AMT_W;
    localparam int WORD_W = KEY_W + QTY_BITS;
    localparam logic [QTY_BITS-1:0] QTY_MAX = '1;

    // Entry memory: key in the upper bits, quantity in the lower bits.
    logic [WORD_W-1:0]   r_mem [ENTRIES];
    logic [WORD_W-1:0]   r_rd_word;

    logic                r_adds_closed;
    logic                r_opcode;
    logic [KEY_W-1:0]    r_key;
    logic [QTY_BITS-1:0] r_amt;
    logic [IDX_W-1:0]    r_scan_idx;
    logic                r_rd_pend;
    logic                r_rd_vld;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [QTY_BITS-1:0] r_hit_qty;
    logic                r_free;
    logic [IDX_W-1:0]    r_free_idx;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [ENTRIES-1:0]  r_valid;
    logic [CNT_W-1:0]    r_count;
    logic [AMT_W-1:0]    r_taken;
    logic [STATUS_W-1:0] r_status;

    logic [WIDE_W-1:0]   amt_wide;
    logic [QTY_BITS-1:0] amt_sat;
    logic [KEY_W-1:0]    rd_key;
    logic [QTY_BITS-1:0] rd_qty;
    logic                rd_match;
    logic                rd_free;
    logic [QTY_BITS:0]   sum_wide;
    logic [QTY_BITS-1:0] sum_sat;
    logic [QTY_BITS-1:0] take_amt;
    logic [QTY_BITS-1:0] remain;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [QTY_BITS-1:0] wr_qty;
    logic                set_valid;
    logic                clr_valid;
    logic [AMT_W-1:0]    n_taken;
    t_kcp_status         n_status;

    // Amounts above the quantity maximum are clipped when the request is captured.
    assign amt_wide = WIDE_W'(i_amount);
    assign amt_sat  = (amt_wide > WIDE_W'(QTY_MAX)) ? QTY_MAX : QTY_BITS'(amt_wide);

    assign rd_key   = r_rd_word[WORD_W-1:QTY_BITS];
    assign rd_qty   = r_rd_word[QTY_BITS-1:0];
    assign rd_match = r_rd_pend && r_rd_vld && (rd_key == r_key);
    assign rd_free  = r_rd_pend && !r_rd_vld;

    assign sum_wide = {1'b0, r_hit_qty} + {1'b0, r_amt};
    assign sum_sat  = sum_wide[QTY_BITS] ? QTY_MAX : sum_wide[QTY_BITS-1:0];
    assign take_amt = (r_hit_qty >= r_amt) ? r_amt : r_hit_qty;
    assign remain   = r_hit_qty - take_amt;

    assign o_sts.scan_last = (r_scan_idx == IDX_W'(ENTRIES - 1));

    always_comb begin
        wr_en     = 1'b0;
        wr_idx    = r_hit_idx;
        wr_qty    = sum_sat;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        n_taken   = '0;
        n_status  = ST_OK;
        if (r_opcode == OP_ADD) begin
            priority if (r_adds_closed) begin
                n_status = ST_CLOSED;
            end else if (r_hit) begin
                wr_en = 1'b1;
            end else if (r_free) begin
                wr_en     = 1'b1;
                wr_idx    = r_free_idx;
                wr_qty    = r_amt;
                set_valid = 1'b1;
            end else begin
                n_status = ST_FULL;
            end
        end else begin
            if (r_hit) begin
                wr_en     = 1'b1;
                wr_qty    = remain;
                n_taken   = AMT_W'(take_amt);
                clr_valid = (remain == '0);
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_word <= r_mem[r_scan_idx];
        end
        if (i_cmd.write && wr_en) begin
            r_mem[wr_idx] <= {r_key, wr_qty};
        end
    end

    // Request capture and result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode <= i_opcode;
            r_key    <= i_key;
            r_amt    <= amt_sat;
        end
        if (i_cmd.scan) begin
            r_rd_idx <= r_scan_idx;
            r_rd_vld <= r_valid[r_scan_idx];
        end
        if (rd_match && !r_hit) begin
            r_hit_idx <= r_rd_idx;
            r_hit_qty <= rd_qty;
        end
        if (rd_free && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.write) begin
            r_taken  <= n_taken;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adds_closed <= 1'b0;
            r_scan_idx    <= '0;
            r_rd_pend     <= 1'b0;
            r_hit         <= 1'b0;
            r_free        <= 1'b0;
            r_valid       <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_adds_closed <= i_cfg_wdata;
            end
            r_rd_pend <= i_cmd.scan;
            if (i_cmd.load) begin
                r_scan_idx <= '0;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                if (rd_match) begin
                    r_hit <= 1'b1;
                end
                if (rd_free) begin
                    r_free <= 1'b1;
                end
            end
            if (i_cmd.write && set_valid) begin
                r_valid[wr_idx] <= 1'b1;
                r_count         <= r_count + 1'b1;
            end else if (i_cmd.write && clr_valid) begin
                r_valid[wr_idx] <= 1'b0;
                r_count         <= r_count - 1'b1;
            end
        end
    end

    assign o_taken     = r_taken;
    assign o_status    = r_status;
    assign o_occupancy = OCC_W'(r_count);
    assign o_is_empty  = (r_count == '0);

    `KCP_ASSERT_RST(a_count_matches_valid, i_clk, i_rst_n, r_count == CNT_W'($countones(r_valid)), "occupancy count disagrees with valid bits")
    `KCP_ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(ENTRIES), "occupancy count exceeds table size")
    `KCP_ASSERT_RST(a_hit_is_valid, i_clk, i_rst_n, (i_cmd.write && r_hit) |-> r_valid[r_hit_idx], "matched entry is not valid at write back")
    `KCP_ASSERT_RST(a_free_is_free, i_clk, i_rst_n, (i_cmd.write && !r_hit && r_free) |-> !r_valid[r_free_idx], "claimed entry is already valid")

endmodule

### rtl/kcp_ctrl.sv
// Controller of the keyed count pool: sequences capture, table scan, write back
// and result transfer. Depends on kcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kcp_ctrl import kcp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_kcp_sts i_sts,
    output t_kcp_cmd o_cmd
);

    t_kcp_state r_state;
    t_kcp_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            // The last entry read is compared during this cycle.
            S_FLUSH: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `KCP_ASSERT_ALWAYS(a_one_side_open, i_clk, !(o_req_ready && o_rsp_valid), "request and result channels open together")
    `KCP_ASSERT_RST(a_scan_continues, i_clk, i_rst_n, (r_state == S_SCAN && !i_sts.scan_last) |=> (r_state == S_SCAN), "scan left before the last entry")
    `KCP_ASSERT_RST(a_result_after_write, i_clk, i_rst_n, $rose(o_rsp_valid) |-> ($past(r_state) == S_WRITE), "result offered without a write back")

endmodule

### rtl/keyed_count_pool_core.sv
// Keyed count pool top level: controller and datapath joined by command/status.
// Depends on kcp_pkg, kcp_ifs, kcp_ctrl and kcp_datapath.
// After a request transfer the controller scans every entry, one entry a cycle through the
// single read port of the entry memory, then passes the flush and write back states and
// offers the result. A new request is taken only after the last result has been taken.
// Reset (synchronous, active low) empties the table and clears the close register.
module keyed_count_pool_core import kcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    kcp_req_if.sink          i_req,
    kcp_rsp_if.source        o_rsp
);

    t_kcp_cmd cmd;
    t_kcp_sts sts;

    kcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    kcp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_opcode    (i_req.opcode),
        .i_key       (i_req.key),
        .i_amount    (i_req.amount),
        .o_taken     (o_rsp.taken),
        .o_status    (o_rsp.status),
        .o_occupancy (o_rsp.occupancy),
        .o_is_empty  (o_rsp.is_empty)
    );

endmodule
